// File: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared codes, widths and controller/datapath bundles for the ring deque.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int ST_W      = 2;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_FILL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic exec;
        logic view;
    } dq_ctrl_t;

    typedef struct packed {
        logic clr_last;
    } dq_stat_t;

endpackage

// File: rtl/core/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: clearing pass after reset, then update, read-back and result.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output dq_pkg::dq_ctrl_t ctrl,
    input  dq_pkg::dq_stat_t stat
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_VIEW  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       load;

    assign busy = (state_reg == S_CLEAR) || (state_reg == S_EXEC) || (state_reg == S_VIEW);
    assign done = (state_reg == S_RESP);
    assign load = start && !busy;

    assign ctrl.load   = load;
    assign ctrl.clr_wr = (state_reg == S_CLEAR);
    assign ctrl.exec   = (state_reg == S_EXEC);
    assign ctrl.view   = (state_reg == S_VIEW);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE, S_RESP:
            begin
                state_next = load ? S_EXEC : S_IDLE;
            end
            S_EXEC:
            begin
                state_next = S_VIEW;
            end
            S_VIEW:
            begin
                state_next = S_RESP;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath
// Ring storage with one write and two registered read ports, head and count
// registers, index wrap logic and result registers.
// ----------------------------------------------------------------------------
module dq_dpath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dq_pkg::dq_ctrl_t                 ctrl,
    output dq_pkg::dq_stat_t                 stat,
    input  logic [dq_pkg::CMD_W-1:0]         command,
    input  logic signed [dq_pkg::WORD_W-1:0] push_data,
    output logic signed [dq_pkg::WORD_W-1:0] popped_data,
    output logic [dq_pkg::ST_W-1:0]          status,
    output logic signed [dq_pkg::WORD_W-1:0] front_value,
    output logic signed [dq_pkg::WORD_W-1:0] back_value,
    output logic [$clog2(DEPTH+1)-1:0]       count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    logic [dq_pkg::WORD_W-1:0] ring_mem [DEPTH];

    logic [dq_pkg::CMD_W-1:0]  cmd_reg;
    logic [dq_pkg::WORD_W-1:0] data_reg;
    logic [AW-1:0]             head_reg;
    logic [AW-1:0]             head_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [dq_pkg::ST_W-1:0]   status_reg;
    logic [dq_pkg::ST_W-1:0]   status_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic [dq_pkg::WORD_W-1:0] popped_reg;
    logic [AW-1:0]             clr_idx_reg;
    logic [dq_pkg::WORD_W-1:0] rd_a_reg;
    logic [dq_pkg::WORD_W-1:0] rd_b_reg;

    logic                      full;
    logic                      empty;
    logic [SW-1:0]             tail_sum;
    logic [SW-1:0]             rear_sum;
    logic [AW-1:0]             tail_pos;
    logic [AW-1:0]             rear_pos;
    logic [AW-1:0]             head_inc;
    logic [AW-1:0]             head_dec;
    logic                      push_we;
    logic [AW-1:0]             push_addr;
    logic [AW-1:0]             pop_addr;
    logic                      we;
    logic [AW-1:0]             wr_addr;
    logic [dq_pkg::WORD_W-1:0] wr_data;
    logic [AW-1:0]             rd_a_addr;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // index wrap, sums stay below twice the depth
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign rear_sum = tail_sum - SW'(1);

    always_comb
    begin
        if (empty)
        begin
            rear_pos = head_dec;
        end
        else if (rear_sum >= SW'(DEPTH))
        begin
            rear_pos = AW'(rear_sum - SW'(DEPTH));
        end
        else
        begin
            rear_pos = AW'(rear_sum);
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = dq_pkg::ST_DONE;
        hit_next    = 1'b0;
        push_we     = 1'b0;
        push_addr   = tail_pos;
        pop_addr    = head_reg;
        case (cmd_reg)
            dq_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    push_we    = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            dq_pkg::CMD_PUSH_FRONT:
            begin
                push_addr = head_dec;
                if (full)
                begin
                    status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    push_we    = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            dq_pkg::CMD_POP_BACK:
            begin
                pop_addr = rear_pos;
                if (empty)
                begin
                    status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    hit_next   = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            dq_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    hit_next   = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = dq_pkg::ST_DONE;
            end
        endcase
    end

    assign we        = ctrl.clr_wr || (ctrl.exec && push_we);
    assign wr_addr   = ctrl.clr_wr ? clr_idx_reg : push_addr;
    assign wr_data   = ctrl.clr_wr ? dq_pkg::WORD_FILL : data_reg;
    assign rd_a_addr = ctrl.view ? head_reg : pop_addr;

    assign stat.clr_last = (clr_idx_reg == AW'(DEPTH - 1));

    // ring storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= ring_mem[rd_a_addr];
        rd_b_reg <= ring_mem[rear_pos];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= command;
            data_reg <= push_data;
        end
        if (ctrl.view)
        begin
            if (hit_reg)
            begin
                popped_reg <= rd_a_reg;
            end
            else if (status_reg == dq_pkg::ST_EMPTY)
            begin
                popped_reg <= dq_pkg::WORD_MIN;
            end
            else
            begin
                popped_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            status_reg  <= dq_pkg::ST_DONE;
            hit_reg     <= 1'b0;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (ctrl.clr_wr)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (ctrl.exec)
            begin
                head_reg   <= head_next;
                count_reg  <= count_next;
                status_reg <= status_next;
                hit_reg    <= hit_next;
            end
        end
    end

    assign popped_data = popped_reg;
    assign status      = status_reg;
    assign front_value = rd_a_reg;
    assign back_value  = rd_b_reg;
    assign count       = count_reg;

endmodule

// File: rtl/core/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result is
// shown for exactly one cycle, marked by done; the receiver cannot stall it.
// A new command may be started in the done cycle but not before it: busy
// stays high while the block updates the ring and indices, then lets the
// ring's registered read ports fetch the new front and back words. Then it
// presents the beat. After reset the block holds busy high while it fills
// the ring with -1.
module circular_deque #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    output logic                             done,
    input  logic [dq_pkg::CMD_W-1:0]         command,
    input  logic signed [dq_pkg::WORD_W-1:0] push_data,
    output logic signed [dq_pkg::WORD_W-1:0] popped_data,
    output logic [dq_pkg::ST_W-1:0]          status,
    output logic signed [dq_pkg::WORD_W-1:0] front_value,
    output logic signed [dq_pkg::WORD_W-1:0] back_value,
    output logic [dq_pkg::COUNT_W-1:0]       entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    dq_pkg::dq_ctrl_t ctrl;
    dq_pkg::dq_stat_t stat;
    logic [CW-1:0]    count;

    dq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .command     (command),
        .push_data   (push_data),
        .popped_data (popped_data),
        .status      (status),
        .front_value (front_value),
        .back_value  (back_value),
        .count       (count)
    );

    assign entry_count = dq_pkg::COUNT_W'(count);

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result beat not three cycles after accept");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(DEPTH))
        else $error("count above depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == dq_pkg::ST_FULL) |-> count == CW'(DEPTH))
        else $error("full refusal with room left");
`endif

endmodule
